// ----- src/max_of_sliding_window_minima_macros.svh -----
// Assertion macros for the RTL of the sliding window minima block.
// Needs nothing else; included by files that carry concurrent assertions.
`ifndef MAX_OF_SLIDING_WINDOW_MINIMA_MACROS_SVH
`define MAX_OF_SLIDING_WINDOW_MINIMA_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSWM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mswm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mswm: next-cycle check failed");

`endif

// ----- src/mswm_pkg.sv -----
// Package for the sliding window minima block: sizes, limits, types.
// Used by the scan unit and the top level; depends on nothing.
`default_nettype none

package mswm_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
	localparam int CFG_W      = 7;

	localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

	localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(WINDOW_MAX);
	localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(WINDOW_MAX - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Command from the sequencer to the scan unit.
	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] count;
		logic [ADDR_W-1:0] base;
	} scan_cmd_t;

	// Window length as used: zero counts as one, large values clamp to the ring size.
	function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] wl);
		logic [LEN_W-1:0] len;
		if (wl == '0) begin
			len = LEN_W'(1);
		end else if ({{(32-CFG_W){1'b0}}, wl} > 32'(WINDOW_MAX)) begin
			len = LEN_MAX;
		end else begin
			len = LEN_W'(wl);
		end
		return len;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_dec(input logic [ADDR_W-1:0] a);
		logic [ADDR_W-1:0] r;
		r = (a == '0) ? ADDR_TOP : a - ADDR_W'(1);
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
		logic [ADDR_W-1:0] r;
		r = (a == ADDR_TOP) ? '0 : a + ADDR_W'(1);
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/max_of_sliding_window_minima.sv -----
// Top level of the sliding window minima block: sequencer, sequence state,
// sample ring and output register. Depends on mswm_pkg, mswm_ram, mswm_scan.
//
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid/cfg_ready    window_length
// in        in         in_valid/in_ready      sample_value, is_last
// out       out        out_valid/out_ready    max_of_minima
//
// An item that completes no window is taken in ST_IDLE; one that completes a window
// moves to ST_SCAN for effective window length - 1 ring reads through
// the single read port and the shared comparator of the scan unit.
// A marked item then passes through ST_DONE to load the output register, waiting while it is full.
// Reset clears the sequence state; the ring needs no clearing and is read only where written.
// A stalled output holds its result and stops the next marked item before it loads.
`default_nettype none

`include "max_of_sliding_window_minima_macros.svh"

module max_of_sliding_window_minima (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [mswm_pkg::CFG_W-1:0]          window_length,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  signed [mswm_pkg::DATA_W-1:0]  sample_value,
	input  wire                                 is_last,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic signed [mswm_pkg::DATA_W-1:0]  max_of_minima
);

	mswm_pkg::state_t state_q, state_d;

	logic        [mswm_pkg::CFG_W-1:0]  wlen_q;
	logic        [mswm_pkg::ADDR_W-1:0] pos_q;
	logic        [mswm_pkg::LEN_W-1:0]  seen_q;
	logic signed [mswm_pkg::DATA_W-1:0] best_q;
	logic signed [mswm_pkg::DATA_W-1:0] partial_q;
	logic                               last_q;
	logic                               out_valid_q;
	logic signed [mswm_pkg::DATA_W-1:0] out_data_q;

	logic                               accept;
	logic        [mswm_pkg::LEN_W-1:0]  len;
	logic        [mswm_pkg::LEN_W-1:0]  seen_clamp;
	logic        [mswm_pkg::LEN_W-1:0]  seen_next;
	logic                               need_scan;
	logic                               out_free;
	logic                               out_load;
	logic                               best_upd;

	mswm_pkg::scan_cmd_t                scan_cmd;
	logic        [mswm_pkg::ADDR_W-1:0] rd_addr;
	logic signed [mswm_pkg::DATA_W-1:0] rd_data;
	logic                               scan_idle;
	logic signed [mswm_pkg::DATA_W-1:0] scan_min;

	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign max_of_minima = out_data_q;
	assign accept        = in_valid && in_ready;
	assign out_free      = !out_valid_q || out_ready;

	assign len        = mswm_pkg::eff_len(wlen_q);
	assign seen_clamp = (seen_q > len) ? len : seen_q;
	assign seen_next  = (seen_clamp < len) ? seen_clamp + mswm_pkg::LEN_W'(1) : seen_clamp;
	assign need_scan  = (seen_next >= len);

	assign scan_cmd.start = accept && need_scan;
	assign scan_cmd.count = mswm_pkg::ADDR_W'(len - mswm_pkg::LEN_W'(1));
	assign scan_cmd.base  = pos_q;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		best_upd = 1'b0;
		unique case (state_q)
			mswm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (need_scan) begin
						state_d = mswm_pkg::ST_SCAN;
					end else if (is_last) begin
						state_d = mswm_pkg::ST_DONE;
					end
				end
			end
			mswm_pkg::ST_SCAN: begin
				if (scan_idle) begin
					best_upd = 1'b1;
					state_d  = last_q ? mswm_pkg::ST_DONE : mswm_pkg::ST_IDLE;
				end
			end
			mswm_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = mswm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mswm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mswm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= mswm_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			wlen_q <= window_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			seen_q    <= '0;
			best_q    <= mswm_pkg::MOST_NEG;
			partial_q <= mswm_pkg::MOST_POS;
			last_q    <= 1'b0;
		end else if (out_load) begin
			pos_q     <= '0;
			seen_q    <= '0;
			best_q    <= mswm_pkg::MOST_NEG;
			partial_q <= mswm_pkg::MOST_POS;
			last_q    <= 1'b0;
		end else if (accept) begin
			pos_q  <= mswm_pkg::addr_inc(pos_q);
			seen_q <= seen_next;
			last_q <= is_last;
			if (sample_value < partial_q) begin
				partial_q <= sample_value;
			end
		end else if (best_upd && (scan_min > best_q)) begin
			best_q <= scan_min;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// With no full window, best_q still holds its start value and the overall minimum wins.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= (best_q == mswm_pkg::MOST_NEG) ? partial_q : best_q;
		end
	end

	mswm_ram #(
		.WIDTH(mswm_pkg::DATA_W),
		.DEPTH(mswm_pkg::WINDOW_MAX)
	) u_ring (
		.clk  (clk),
		.we   (accept),
		.waddr(pos_q),
		.wdata(sample_value),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	mswm_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (scan_cmd),
		.init_value(sample_value),
		.rd_data   (rd_data),
		.rd_addr   (rd_addr),
		.idle      (scan_idle),
		.min_value (scan_min)
	);

	`MSWM_ASSERT_NEXT(a_scan_blocks_input, clk, arst_n, scan_cmd.start, !in_ready)
	`MSWM_ASSERT_IMPLY(a_done_after_scan, clk, arst_n, state_q == mswm_pkg::ST_DONE, scan_idle)
	`MSWM_ASSERT_IMPLY(a_result_from_done, clk, arst_n, $rose(out_valid),
		$past(state_q) == mswm_pkg::ST_DONE)

endmodule

`default_nettype wire

// ----- src/mswm_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Standalone; sized by its parameters.
`default_nettype none

module mswm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire                                           clk,
	input  wire                                           we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  wire  [WIDTH-1:0]                              wdata,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- src/mswm_scan.sv -----
// Scan unit: walks back through the sample ring one entry a cycle and keeps
// the running minimum through a single comparator. Depends on mswm_pkg.
`default_nettype none

module mswm_scan (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire  mswm_pkg::scan_cmd_t               cmd,
	input  wire  signed [mswm_pkg::DATA_W-1:0]      init_value,
	input  wire  signed [mswm_pkg::DATA_W-1:0]      rd_data,
	output logic        [mswm_pkg::ADDR_W-1:0]      rd_addr,
	output logic                                    idle,
	output logic signed [mswm_pkg::DATA_W-1:0]      min_value
);

	logic        [mswm_pkg::ADDR_W-1:0] remain_q;
	logic        [mswm_pkg::ADDR_W-1:0] addr_q;
	logic                               pend_s1;
	logic signed [mswm_pkg::DATA_W-1:0] acc_q;
	logic                               issue;

	assign issue     = (remain_q != '0);
	assign rd_addr   = addr_q;
	assign idle      = !issue && !pend_s1;
	assign min_value = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
			pend_s1  <= 1'b0;
		end else if (cmd.start) begin
			remain_q <= cmd.count;
			pend_s1  <= 1'b0;
		end else begin
			remain_q <= issue ? remain_q - mswm_pkg::ADDR_W'(1) : remain_q;
			pend_s1  <= issue;
		end
	end

	// The newest sample seeds the minimum, so reads start one slot behind it.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q <= mswm_pkg::addr_dec(cmd.base);
			acc_q  <= init_value;
		end else begin
			if (issue) begin
				addr_q <= mswm_pkg::addr_dec(addr_q);
			end
			if (pend_s1 && (rd_data < acc_q)) begin
				acc_q <= rd_data;
			end
		end
	end

endmodule

`default_nettype wire
